>>> sv/lcru_pkg.sv
// shared types and constants for the capture rle sample unpacker
// no dependencies
package lcru_pkg;

	localparam int NUM_GROUPS  = 4;
	localparam int BYTE_W      = 8;
	localparam int GROUP_CNT_W = 3;
	localparam int SAMPLE_W    = NUM_GROUPS * BYTE_W;
	localparam int RUN_W       = 31;
	localparam int LIMIT_W     = 25;
	localparam int SLOT_W      = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = LIMIT_W;
	localparam int RUN_FLAG_BIT = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'h100_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GROUP_DISABLE = 2'd0,
		CFG_RLE_ENABLE    = 2'd1,
		CFG_SAMPLE_LIMIT  = 2'd2
	} cfg_idx_t;

	// completed data sample handed to the run tracker
	typedef struct packed {
		logic                emit;
		logic [SAMPLE_W-1:0] value;
		logic [RUN_W-1:0]    run;
	} smp_t;

endpackage

>>> sv/lcru_assembler.sv
// byte assembly: gathers bytes into samples, separates run counts from data
// depends on lcru_pkg
module lcru_assembler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take_en,
	input  logic [lcru_pkg::BYTE_W-1:0]       byte_s1,
	input  logic [lcru_pkg::NUM_GROUPS-1:0]   group_disable,
	input  logic                              rle_enable,
	input  logic                              capture_full,
	output lcru_pkg::smp_t                    smp
);

	logic [lcru_pkg::BYTE_W-1:0]      store_q [lcru_pkg::NUM_GROUPS];
	logic [lcru_pkg::GROUP_CNT_W-1:0] held_q;
	logic [lcru_pkg::RUN_W-1:0]       pending_q;

	logic [lcru_pkg::BYTE_W-1:0]      cur [lcru_pkg::NUM_GROUPS];
	logic [lcru_pkg::GROUP_CNT_W-1:0] nch;
	logic [lcru_pkg::GROUP_CNT_W-1:0] held_n;
	logic [lcru_pkg::GROUP_CNT_W-1:0] j;
	logic [1:0]                       last;
	logic                             take;
	logic                             complete;
	logic                             is_run;
	logic [lcru_pkg::SAMPLE_W-1:0]    packed_w;
	logic [lcru_pkg::SAMPLE_W-1:0]    run_word;
	logic [lcru_pkg::SAMPLE_W-1:0]    expanded;

	always_comb begin
		nch = '0;
		for (int i = 0; i < lcru_pkg::NUM_GROUPS; i++) begin
			nch = nch + {2'b00, ~group_disable[i]};
		end
	end

	always_comb begin
		for (int i = 0; i < lcru_pkg::NUM_GROUPS; i++) begin
			cur[i] = (held_q[1:0] == 2'(i)) ? byte_s1 : store_q[i];
		end
	end

	assign take     = take_en && (nch != '0) && !capture_full;
	assign held_n   = held_q + 3'd1;
	assign complete = take && (held_n >= nch);
	assign last     = 2'(nch - 3'd1);
	assign is_run   = rle_enable && cur[last][lcru_pkg::RUN_FLAG_BIT];

	always_comb begin
		packed_w = '0;
		for (int i = 0; i < lcru_pkg::NUM_GROUPS; i++) begin
			if (3'(i) < nch) begin
				packed_w[lcru_pkg::BYTE_W*i +: lcru_pkg::BYTE_W] = cur[i];
			end
		end
		run_word = packed_w;
		run_word[{last, 3'd7}] = 1'b0;
	end

	// enabled groups take the received bytes in order, disabled groups read zero
	always_comb begin
		expanded = '0;
		j = '0;
		for (int i = 0; i < lcru_pkg::NUM_GROUPS; i++) begin
			if (!group_disable[i]) begin
				expanded[lcru_pkg::BYTE_W*i +: lcru_pkg::BYTE_W] = cur[j[1:0]];
				j = j + 3'd1;
			end
		end
	end

	assign smp.emit  = complete && !is_run;
	assign smp.value = expanded;
	assign smp.run   = pending_q;

	always_ff @(posedge clk) begin
		if (take) begin
			store_q[held_q[1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			pending_q <= '0;
		end else if (take) begin
			if (complete) begin
				held_q    <= '0;
				pending_q <= is_run ? run_word[lcru_pkg::RUN_W-1:0] : '0;
			end else begin
				held_q <= held_n;
			end
		end
	end

endmodule

>>> sv/lcru_run_tracker.sv
// run tracking: sample count, clamp to the limit, result register
// depends on lcru_pkg
module lcru_run_tracker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lcru_pkg::smp_t                   smp,
	input  logic [lcru_pkg::LIMIT_W-1:0]     sample_limit,
	input  logic                             out_stall,
	output logic                             capture_full,
	output logic                             out_valid,
	output logic [lcru_pkg::SAMPLE_W-1:0]    sample_value,
	output logic [lcru_pkg::LIMIT_W-1:0]     repeat_times,
	output logic [lcru_pkg::SLOT_W-1:0]      first_slot,
	output logic                             limit_reached
);

	logic [lcru_pkg::LIMIT_W-1:0] taken_q;
	logic [31:0]                  total;
	logic [32:0]                  diff;
	logic                         over;
	logic [lcru_pkg::LIMIT_W-1:0] room;
	logic [lcru_pkg::LIMIT_W-1:0] rep_n;
	logic [lcru_pkg::LIMIT_W-1:0] taken_n;

	assign capture_full = taken_q >= sample_limit;

	assign total   = {7'd0, taken_q} + {1'b0, smp.run} + 32'd1;
	assign diff    = {8'd0, sample_limit} - {1'b0, total};
	assign over    = diff[32];
	assign room    = sample_limit - taken_q;
	assign rep_n   = over ? room : total[lcru_pkg::LIMIT_W-1:0] - taken_q;
	assign taken_n = over ? sample_limit : total[lcru_pkg::LIMIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (smp.emit) begin
				taken_q   <= taken_n;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (smp.emit) begin
			sample_value  <= smp.value;
			repeat_times  <= rep_n;
			first_slot    <= over ? '0 : diff[lcru_pkg::SLOT_W-1:0];
			limit_reached <= over || (diff == '0);
		end
	end

endmodule

>>> sv/logic_capture_rle_sample_unpacker.sv
// top level of the capture rle sample unpacker
// depends on lcru_pkg, lcru_assembler and lcru_run_tracker
//
// usage:
//  - input channel (in_valid, in_stall, rx_byte) carries one capture byte per transfer
//  - output channel (out_valid, out_stall, sample_value, repeat_times, first_slot,
//    limit_reached) carries one expanded data sample per transfer
//  - bytes of a sample arrive little-endian, one per enabled channel group; a
//    completed run count or a partial sample gives no output transfer
//  - configuration is written through cfg_wr_en / cfg_index / cfg_data while idle
//  - a byte passes through the input register, then the result register, on its way
//    to the output
//  - throughput: one byte per cycle while out_stall does not hold a result, set by the
//    update of the held byte count and the sample count
//  - once the sample count reaches the limit, or with all groups disabled, bytes
//    are taken and dropped
//  - reset clears the held byte count, pending run, sample count and registers to their
//    defaults (limit 2^24, all groups on, rle off)
//  - while out_stall holds a result, at most one byte is buffered, then in_stall rises
module logic_capture_rle_sample_unpacker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [lcru_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lcru_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lcru_pkg::BYTE_W-1:0]         rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lcru_pkg::SAMPLE_W-1:0]       sample_value,
	output logic [lcru_pkg::LIMIT_W-1:0]        repeat_times,
	output logic [lcru_pkg::SLOT_W-1:0]         first_slot,
	output logic                                limit_reached
);

	logic [lcru_pkg::NUM_GROUPS-1:0] group_disable_q;
	logic                            rle_enable_q;
	logic [lcru_pkg::LIMIT_W-1:0]    sample_limit_q;

	logic                            valid_s1;
	logic [lcru_pkg::BYTE_W-1:0]     byte_s1;
	logic                            advance;
	logic                            take_en;
	logic                            capture_full;
	lcru_pkg::smp_t                  smp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_disable_q <= '0;
			rle_enable_q    <= 1'b0;
			sample_limit_q  <= lcru_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			case (lcru_pkg::cfg_idx_t'(cfg_index))
				lcru_pkg::CFG_GROUP_DISABLE: begin
					group_disable_q <= cfg_data[lcru_pkg::NUM_GROUPS-1:0];
				end
				lcru_pkg::CFG_RLE_ENABLE: begin
					rle_enable_q <= cfg_data[0];
				end
				lcru_pkg::CFG_SAMPLE_LIMIT: begin
					sample_limit_q <= cfg_data[lcru_pkg::LIMIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign advance  = !(out_valid && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_en  = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	lcru_assembler u_asm (
		.clk           (clk),
		.arst_n        (arst_n),
		.take_en       (take_en),
		.byte_s1       (byte_s1),
		.group_disable (group_disable_q),
		.rle_enable    (rle_enable_q),
		.capture_full  (capture_full),
		.smp           (smp)
	);

	lcru_run_tracker u_trk (
		.clk           (clk),
		.arst_n        (arst_n),
		.smp           (smp),
		.sample_limit  (sample_limit_q),
		.out_stall     (out_stall),
		.capture_full  (capture_full),
		.out_valid     (out_valid),
		.sample_value  (sample_value),
		.repeat_times  (repeat_times),
		.first_slot    (first_slot),
		.limit_reached (limit_reached)
	);

`ifndef ASSERT_OFF
	a_no_emit_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(smp.emit && capture_full))
		else $error("sample emitted after the limit was reached");

	a_emit_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		smp.emit |=> out_valid && (repeat_times != '0))
		else $error("emitted sample missing or with zero repeat count");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled with nothing held");
`endif

endmodule

>>> bench/lcru_checker.sv
// scoreboard for the capture rle sample unpacker: follows config writes and byte
// transfers, predicts every expanded sample and compares each output transfer
// depends on lcru_pkg
module lcru_checker
	import lcru_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [BYTE_W-1:0]     rx_byte,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [SAMPLE_W-1:0]   sample_value,
	input  logic [LIMIT_W-1:0]    repeat_times,
	input  logic [SLOT_W-1:0]     first_slot,
	input  logic                  limit_reached,
	output int                    fail_count,
	output int                    open_count,
	output logic [LIMIT_W-1:0]    taken_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic [LIMIT_W-1:0]  reps;
		logic [SLOT_W-1:0]   slot;
		logic                hit;
	} sample_t;

	sample_t sample_q[$];

	logic [NUM_GROUPS-1:0] grp_off;
	logic                  rle_on;
	logic [LIMIT_W-1:0]    limit;
	logic [BYTE_W-1:0]     held [NUM_GROUPS];
	logic [2:0]            held_cnt;
	logic [RUN_W-1:0]      run_pend;

	task automatic drop_held();
		int i;
		for (i = 0; i < NUM_GROUPS; i++)
			held[i] = '0;
		held_cnt = '0;
	endtask

	// gathers one byte, queues the expanded sample when a data sample completes
	task automatic unpack_byte(input logic [BYTE_W-1:0] b);
		int n;
		int i;
		int j;
		logic [SAMPLE_W-1:0] word;
		logic [SAMPLE_W-1:0] wide;
		longint unsigned run;
		longint unsigned total;
		sample_t s;
		n = $countones(~grp_off);
		if (n == 0 || taken_count >= limit)
			return;
		held[held_cnt[1:0]] = b;
		held_cnt = held_cnt + 3'd1;
		if (held_cnt < n)
			return;
		word = '0;
		for (i = 0; i < n; i++)
			word |= SAMPLE_W'(held[i]) << (BYTE_W * i);
		if (rle_on && held[n-1][RUN_FLAG_BIT]) begin
			run_pend = RUN_W'(word & ~(SAMPLE_W'(1) << (BYTE_W * (n - 1) + RUN_FLAG_BIT)));
			drop_held();
			return;
		end
		run = 64'(run_pend);
		total = 64'(taken_count) + run + 64'd1;
		if (total > 64'(limit)) begin
			run -= total - 64'(limit);
			total = 64'(limit);
		end
		taken_count = LIMIT_W'(total);
		wide = '0;
		j = 0;
		for (i = 0; i < NUM_GROUPS; i++) begin
			if (!grp_off[i]) begin
				wide |= SAMPLE_W'(held[j]) << (BYTE_W * i);
				j++;
			end
		end
		s.value = wide;
		s.reps  = LIMIT_W'(run + 64'd1);
		s.slot  = SLOT_W'(limit - taken_count);
		s.hit   = (taken_count >= limit);
		sample_q.push_back(s);
		drop_held();
		run_pend = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sample_t e;
		if (!arst_n) begin
			grp_off     = '0;
			rle_on      = 1'b0;
			limit       = LIMIT_RESET;
			run_pend    = '0;
			taken_count = '0;
			fail_count  = 0;
			drop_held();
			sample_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (sample_q.size() == 0) begin
					$display("%0t: unexpected sample: expected none, got %h", $time, sample_value);
					fail_count++;
				end else begin
					e = sample_q.pop_front();
					if (sample_value !== e.value) begin
						$display("%0t: sample_value expected %h got %h", $time, e.value,
							sample_value);
						fail_count++;
					end
					if (repeat_times !== e.reps) begin
						$display("%0t: repeat_times expected %0d got %0d", $time, e.reps,
							repeat_times);
						fail_count++;
					end
					if (first_slot !== e.slot) begin
						$display("%0t: first_slot expected %0d got %0d", $time, e.slot,
							first_slot);
						fail_count++;
					end
					if (limit_reached !== e.hit) begin
						$display("%0t: limit_reached expected %b got %b", $time, e.hit,
							limit_reached);
						fail_count++;
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_idx_t'(cfg_index))
					CFG_GROUP_DISABLE: grp_off = cfg_data[NUM_GROUPS-1:0];
					CFG_RLE_ENABLE:    rle_on  = cfg_data[0];
					CFG_SAMPLE_LIMIT:  limit   = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				unpack_byte(rx_byte);
		end
		open_count = sample_q.size();
	end

endmodule

>>> bench/tb_logic_capture_rle_sample_unpacker.sv
// top of the capture rle sample unpacker bench: clock, reset, config phases and
// byte stimulus with random idling; the verdict comes from lcru_checker
// depends on lcru_pkg, lcru_checker and logic_capture_rle_sample_unpacker
module tb_logic_capture_rle_sample_unpacker;
	timeunit 1ns;
	timeprecision 1ps;
	import lcru_pkg::*;

	localparam int ITEM_TARGET  = 950;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES  = 64;

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [BYTE_W-1:0]     rx_byte    = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [SAMPLE_W-1:0]   sample_value;
	logic [LIMIT_W-1:0]    repeat_times;
	logic [SLOT_W-1:0]     first_slot;
	logic                  limit_reached;
	int                    fail_count;
	int                    open_count;
	logic [LIMIT_W-1:0]    taken_count;

	bit calm          = 1'b0;
	bit pressure_go   = 1'b0;
	bit pressure_done = 1'b0;
	int items         = 0;
	int stall_left    = 0;
	int cycle_cnt     = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	logic_capture_rle_sample_unpacker u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_value  (sample_value),
		.repeat_times  (repeat_times),
		.first_slot    (first_slot),
		.limit_reached (limit_reached)
	);

	lcru_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sample_value  (sample_value),
		.repeat_times  (repeat_times),
		.first_slot    (first_slot),
		.limit_reached (limit_reached),
		.fail_count    (fail_count),
		.open_count    (open_count),
		.taken_count   (taken_count)
	);

	// receiver side: random stall bursts, plus one long hold-off to back the block up
	initial begin
		forever begin
			@(posedge clk);
			if (pressure_go && !pressure_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				pressure_done = 1'b1;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** logic_capture_rle_sample_unpacker: FAILED **");
		$finish;
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		bit done;
		in_valid <= 1'b1;
		rx_byte  <= b;
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			done = !in_stall;
			@(posedge clk);
		end
		items++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// little-endian, one byte per enabled group
	task automatic push_word(input int n, input logic [SAMPLE_W-1:0] w);
		int i;
		for (i = 0; i < n; i++)
			push_byte(w[BYTE_W*i +: BYTE_W]);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (open_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [NUM_GROUPS-1:0] gd, input logic rle,
			input logic [LIMIT_W-1:0] lim);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_GROUP_DISABLE;
		cfg_data  <= CFG_DATA_W'(gd);
		@(posedge clk);
		cfg_index <= CFG_RLE_ENABLE;
		cfg_data  <= CFG_DATA_W'(rle);
		@(posedge clk);
		cfg_index <= CFG_SAMPLE_LIMIT;
		cfg_data  <= lim;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// mostly whole samples; run counts mostly short so the limit lasts, rare stray bytes
	task automatic random_sample(input int n, input logic rle);
		logic [SAMPLE_W-1:0] w;
		logic [SAMPLE_W-1:0] flag;
		int k;
		k = $urandom_range(0, 39);
		w = $urandom();
		flag = SAMPLE_W'(1) << (BYTE_W * (n - 1) + RUN_FLAG_BIT);
		if (k == 0) begin
			push_byte(BYTE_W'($urandom_range(0, 255)));
		end else if (rle && k == 1) begin
			push_word(n, w | flag);
		end else if (rle && k < 12) begin
			push_word(n, SAMPLE_W'($urandom_range(0, 15)) | flag);
		end else begin
			if (rle)
				w &= ~flag;
			push_word(n, w);
		end
	endtask

	initial begin
		logic [NUM_GROUPS-1:0] gd;
		logic                  rle;
		logic [LIMIT_W-1:0]    lim;
		bit                    live;
		int                    n;
		int                    s;
		int                    nsamp;
		int                    phase;
		int                    items_before;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest limit: one sample, then bytes are dropped
		set_regs('0, 1'b0, 25'd1);
		push_word(4, 32'h0000_0000);
		push_byte(8'hff);
		settle();

		lim = taken_count + 25'd8;
		set_regs('0, 1'b0, lim);
		push_word(4, 32'hffff_ffff);
		settle();

		// all groups off
		set_regs('1, 1'b0, lim);
		push_word(2, 32'h0000_a55a);
		settle();

		// run count held over while rle is switched off
		set_regs(4'b1010, 1'b1, lim);
		push_word(2, 32'h0000_8003);
		settle();
		set_regs(4'b1010, 1'b0, lim);
		push_word(2, 32'h0000_3412);
		settle();

		// group count drops in mid-sample
		set_regs('0, 1'b0, lim);
		push_word(2, 32'h0000_bbaa);
		settle();
		set_regs(4'b0111, 1'b0, lim);
		push_byte(8'hcc);
		settle();

		// run clamped at the limit, then bytes ignored
		lim = taken_count + 25'd3;
		set_regs(4'b1110, 1'b1, lim);
		push_byte(8'hff);
		push_byte(8'h7f);
		push_byte(8'h55);
		settle();

		items = 0;
		phase = 0;
		while (items < ITEM_TARGET) begin
			gd = NUM_GROUPS'($urandom_range(0, 14));
			if ($urandom_range(0, 9) == 0)
				gd = '1;
			rle = 1'($urandom_range(0, 1));
			calm = (items > ITEM_TARGET * 7 / 8) || ($urandom_range(0, 3) == 0);
			lim = taken_count + LIMIT_W'($urandom_range(20, 300));
			if (taken_count > 0 && $urandom_range(0, 9) == 0)
				lim = LIMIT_W'($urandom_range(1, taken_count));
			live = (gd != '1) && (lim > taken_count);
			n = $countones(~gd);
			set_regs(gd, rle, lim);
			if (live && phase >= 1)
				pressure_go = 1'b1;
			items_before = items;
			nsamp = live ? $urandom_range(8, 40) : 3;
			for (s = 0; s < nsamp; s++) begin
				if (live)
					random_sample(n, rle);
				else
					push_byte(BYTE_W'($urandom_range(0, 255)));
			end
			if (!live)
				items = items_before;
			settle();
			phase++;
		end

		// largest limit with the longest run: fills the sample count up to the limit
		calm = 1'b1;
		set_regs('0, 1'b1, LIMIT_RESET);
		push_word(4, 32'hffff_ffff);
		push_word(4, 32'h0102_0304);
		push_word(2, 32'h0000_00ff);
		settle();

		if (fail_count == 0)
			$display("** logic_capture_rle_sample_unpacker: PASSED **");
		else
			$display("** logic_capture_rle_sample_unpacker: FAILED **");
		$finish;
	end

endmodule

>>> logic_capture_rle_sample_unpacker.f
sv/lcru_pkg.sv
sv/lcru_assembler.sv
sv/lcru_run_tracker.sv
sv/logic_capture_rle_sample_unpacker.sv
bench/lcru_checker.sv
bench/tb_logic_capture_rle_sample_unpacker.sv
